### sv/skv_pkg.sv
package skv_pkg;

  localparam int DEPTH       = 1024;
  localparam int KEY_WIDTH   = 64;
  localparam int VALUE_WIDTH = 64;
  localparam int ADDR_W      = $clog2(DEPTH);
  localparam int CNT_W       = $clog2(DEPTH + 1);

  localparam int PORT_KEY_W   = 64;
  localparam int PORT_VALUE_W = 64;
  localparam int PORT_POS_W   = 10;
  localparam int PORT_CNT_W   = 11;
  localparam int STATUS_W     = 3;

  typedef enum logic [0:0] {
    MODE_INSERT = 1'b0,
    MODE_LOOKUP = 1'b1
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED = 3'd0,
    ST_REPLACED = 3'd1,
    ST_DROPPED  = 3'd2,
    ST_HIT      = 3'd3,
    ST_MISS     = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_CHECK,
    S_SHIFT_RD,
    S_SHIFT,
    S_PLACE
  } state_t;

  typedef struct packed {
    logic eq;
    logic lt;
  } cmp_t;

  typedef struct packed {
    logic [ADDR_W-1:0]      rd_addr;
    logic                   key_we;
    logic                   val_we;
    logic [ADDR_W-1:0]      wr_addr;
    logic [KEY_WIDTH-1:0]   key_wdata;
    logic [VALUE_WIDTH-1:0] val_wdata;
  } mem_req_t;

endpackage

### sv/skv_ram.sv
module skv_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### sv/skv_cmp.sv
module skv_cmp (
  input  logic [skv_pkg::KEY_WIDTH-1:0] a,
  input  logic [skv_pkg::KEY_WIDTH-1:0] b,
  output skv_pkg::cmp_t                 res
);

  import skv_pkg::*;

  always_comb begin
    res.eq = (a == b);
    res.lt = (a < b);
  end

endmodule

### sv/skv_ctrl.sv
module skv_ctrl (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic                            mode,
  input  logic [skv_pkg::KEY_WIDTH-1:0]   key,
  input  logic [skv_pkg::VALUE_WIDTH-1:0] value,
  output logic                            busy,
  input  skv_pkg::cmp_t                   cmp,
  input  logic [skv_pkg::KEY_WIDTH-1:0]   key_rd,
  input  logic [skv_pkg::VALUE_WIDTH-1:0] val_rd,
  output logic [skv_pkg::KEY_WIDTH-1:0]   cmp_key,
  output skv_pkg::mem_req_t               mem_req,
  output logic                            done,
  output skv_pkg::status_t                status,
  output logic [skv_pkg::VALUE_WIDTH-1:0] result_value,
  output logic [skv_pkg::ADDR_W-1:0]      position,
  output logic [skv_pkg::CNT_W-1:0]       entry_count
);

  import skv_pkg::*;

  state_t                 state, state_next;
  logic [CNT_W-1:0]       lo, hi, count;
  logic [CNT_W-1:0]       mid_sum;
  logic [ADDR_W-1:0]      mid_next, mid, ptr, pos;
  logic [ADDR_W-1:0]      last_addr;
  mode_t                  mode_q;
  logic [KEY_WIDTH-1:0]   k_q;
  logic [VALUE_WIDTH-1:0] v_q;
  logic                   open;
  logic                   full;

  logic                   fin;
  status_t                fin_status;
  logic [ADDR_W-1:0]      fin_pos;
  logic [VALUE_WIDTH-1:0] fin_val;

  assign mid_sum   = lo + ((hi - lo) >> 1);
  assign mid_next  = mid_sum[ADDR_W-1:0];
  assign open      = (lo < hi);
  assign full      = (count == CNT_W'(DEPTH));
  assign last_addr = ADDR_W'(count - CNT_W'(1));
  assign cmp_key   = k_q;
  assign busy      = (state != S_IDLE);
  assign entry_count = count;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) state_next = S_SEARCH;
      end
      S_SEARCH: begin
        if (open) begin
          state_next = S_CHECK;
        end else if (mode_q == MODE_LOOKUP || full) begin
          state_next = S_IDLE;
        end else if (lo == count) begin
          state_next = S_PLACE;
        end else begin
          state_next = S_SHIFT_RD;
        end
      end
      S_CHECK: begin
        state_next = cmp.eq ? S_IDLE : S_SEARCH;
      end
      S_SHIFT_RD: state_next = S_SHIFT;
      S_SHIFT: begin
        if (ptr == pos) state_next = S_PLACE;
      end
      S_PLACE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    mem_req.rd_addr   = mid_next;
    mem_req.key_we    = 1'b0;
    mem_req.val_we    = 1'b0;
    mem_req.wr_addr   = pos;
    mem_req.key_wdata = k_q;
    mem_req.val_wdata = v_q;
    fin        = 1'b0;
    fin_status = ST_MISS;
    fin_pos    = '0;
    fin_val    = '0;
    case (state)
      S_SEARCH: begin
        if (!open) begin
          if (mode_q == MODE_LOOKUP) begin
            fin        = 1'b1;
            fin_status = ST_MISS;
          end else if (full) begin
            fin        = 1'b1;
            fin_status = ST_DROPPED;
          end
        end
      end
      S_CHECK: begin
        if (cmp.eq) begin
          fin     = 1'b1;
          fin_pos = mid;
          if (mode_q == MODE_LOOKUP) begin
            fin_status = ST_HIT;
            fin_val    = val_rd;
          end else begin
            fin_status     = ST_REPLACED;
            mem_req.val_we = 1'b1;
            mem_req.wr_addr = mid;
          end
        end
      end
      S_SHIFT_RD: begin
        mem_req.rd_addr = last_addr;
      end
      S_SHIFT: begin
        mem_req.rd_addr   = ptr - ADDR_W'(1);
        mem_req.key_we    = 1'b1;
        mem_req.val_we    = 1'b1;
        mem_req.wr_addr   = ptr + ADDR_W'(1);
        mem_req.key_wdata = key_rd;
        mem_req.val_wdata = val_rd;
      end
      S_PLACE: begin
        mem_req.key_we = 1'b1;
        mem_req.val_we = 1'b1;
        fin        = 1'b1;
        fin_status = ST_INSERTED;
        fin_pos    = pos;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= fin;
      if (state == S_PLACE) begin
        count <= count + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fin) begin
      status       <= fin_status;
      position     <= fin_pos;
      result_value <= fin_val;
    end
    case (state)
      S_IDLE: begin
        if (start) begin
          mode_q <= mode_t'(mode);
          k_q    <= key;
          v_q    <= value;
          lo     <= '0;
          hi     <= count;
        end
      end
      S_SEARCH: begin
        if (open) begin
          mid <= mid_next;
        end else begin
          pos <= lo[ADDR_W-1:0];
        end
      end
      S_CHECK: begin
        if (!cmp.eq) begin
          if (cmp.lt) begin
            hi <= CNT_W'(mid);
          end else begin
            lo <= CNT_W'(mid) + CNT_W'(1);
          end
        end
      end
      S_SHIFT_RD: ptr <= last_addr;
      S_SHIFT: ptr <= ptr - ADDR_W'(1);
      default: begin
      end
    endcase
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("Entry count exceeds the table depth.");

  a_search_order: assert property (@(posedge clk) disable iff (rst)
    (state == S_SEARCH || state == S_CHECK) |-> (lo <= hi && hi <= count))
    else $error("Search bounds are out of order.");

  a_done_follows_work: assert property (@(posedge clk) disable iff (rst)
    fin |=> (done && state == S_IDLE))
    else $error("A finished item did not return to idle with a result.");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_INSERTED) |-> count == CNT_W'($past(count) + CNT_W'(1)))
    else $error("An insert did not grow the table by one entry.");

  a_shift_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SHIFT) |-> (ptr >= pos && !full))
    else $error("Shift pointer went below the insert position.");

endmodule

### sv/sorted_key_value_table_insert_lookup_core.sv
// Sorted key/value table with up to 1024 entries of 64-bit keys and values, held in
// single-port-write, registered-read block RAMs. Pulse start while busy is low to hand in
// one beat; busy stays high until the item is finished, and its result appears for exactly
// one cycle with done high, so the receiver must take it then. Each binary-search probe
// reads the RAM in the search state and compares the key in the check state. Inserting
// a new key moves every entry at or above its position up by one slot; the shift reads
// and writes one entry per cycle. No clearing pass is needed after reset.
module sorted_key_value_table_insert_lookup_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic                              mode,
  input  logic [skv_pkg::PORT_KEY_W-1:0]    key,
  input  logic [skv_pkg::PORT_VALUE_W-1:0]  value,
  output logic                              done,
  output logic [skv_pkg::STATUS_W-1:0]      status,
  output logic [skv_pkg::PORT_VALUE_W-1:0]  result_value,
  output logic [skv_pkg::PORT_POS_W-1:0]    position,
  output logic [skv_pkg::PORT_CNT_W-1:0]    entry_count
);

  import skv_pkg::*;

  cmp_t                   cmp;
  mem_req_t               mem_req;
  logic [KEY_WIDTH-1:0]   key_rd;
  logic [VALUE_WIDTH-1:0] val_rd;
  logic [KEY_WIDTH-1:0]   cmp_key;
  status_t                status_q;
  logic [VALUE_WIDTH-1:0] result_q;
  logic [ADDR_W-1:0]      pos_q;
  logic [CNT_W-1:0]       count_q;

  skv_ram #(
    .WIDTH (KEY_WIDTH),
    .DEPTH (DEPTH)
  ) u_key_ram (
    .clk     (clk),
    .we      (mem_req.key_we),
    .wr_addr (mem_req.wr_addr),
    .wr_data (mem_req.key_wdata),
    .rd_addr (mem_req.rd_addr),
    .rd_data (key_rd)
  );

  skv_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (DEPTH)
  ) u_val_ram (
    .clk     (clk),
    .we      (mem_req.val_we),
    .wr_addr (mem_req.wr_addr),
    .wr_data (mem_req.val_wdata),
    .rd_addr (mem_req.rd_addr),
    .rd_data (val_rd)
  );

  skv_cmp u_cmp (
    .a   (cmp_key),
    .b   (key_rd),
    .res (cmp)
  );

  skv_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .mode         (mode),
    .key          (key[KEY_WIDTH-1:0]),
    .value        (value[VALUE_WIDTH-1:0]),
    .busy         (busy),
    .cmp          (cmp),
    .key_rd       (key_rd),
    .val_rd       (val_rd),
    .cmp_key      (cmp_key),
    .mem_req      (mem_req),
    .done         (done),
    .status       (status_q),
    .result_value (result_q),
    .position     (pos_q),
    .entry_count  (count_q)
  );

  assign status       = status_q;
  assign result_value = PORT_VALUE_W'(result_q);
  assign position     = PORT_POS_W'(pos_q);
  assign entry_count  = PORT_CNT_W'(count_q);

endmodule
